[src/rpt_pkg.sv]
// Shared types, constants and the arctangent table of the rigid pose transform.
package rpt_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ANG_TAB_LEN = 30;
	localparam int NSTG = (CORDIC_STAGES < ANG_TAB_LEN) ? CORDIC_STAGES : ANG_TAB_LEN;

	// Angle datapath width (Q.30 radians with headroom for the pi reduction).
	localparam int AW = 34;
	// Width of sine and cosine after rounding to Q.16.
	localparam int SCW = 18;
	// Width of the vectoring datapath.
	localparam int VW = 56;
	localparam int CFG_IW = 3;

	localparam logic signed [AW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [AW-1:0] PI_HALF_Q30 = 34'sd1686629713;
	localparam logic signed [AW-1:0] CORDIC_K_Q30 = 34'sd652032874;

	localparam logic [CFG_IW-1:0] REG_ROT_W = 3'd0;
	localparam logic [CFG_IW-1:0] REG_ROT_X = 3'd1;
	localparam logic [CFG_IW-1:0] REG_ROT_Y = 3'd2;
	localparam logic [CFG_IW-1:0] REG_ROT_Z = 3'd3;
	localparam logic [CFG_IW-1:0] REG_SHIFT_X = 3'd4;
	localparam logic [CFG_IW-1:0] REG_SHIFT_Y = 3'd5;
	localparam logic [CFG_IW-1:0] REG_SHIFT_Z = 3'd6;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] yaw_in;
		logic signed [15:0] pitch_in;
		logic signed [15:0] roll_in;
	} pose_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [15:0] yaw_out;
		logic signed [15:0] pitch_out;
		logic signed [15:0] roll_out;
	} result_t;

	// atan(2^-i) in Q.30 radians.
	function automatic logic signed [AW-1:0] ang_at(input int i);
		case (i)
			0: return 34'sd843314856;
			1: return 34'sd497837829;
			2: return 34'sd263043836;
			3: return 34'sd133525158;
			4: return 34'sd67021686;
			5: return 34'sd33543515;
			6: return 34'sd16775850;
			7: return 34'sd8388437;
			8: return 34'sd4194282;
			9: return 34'sd2097149;
			10: return 34'sd1048575;
			11: return 34'sd524287;
			12: return 34'sd262143;
			13: return 34'sd131071;
			14: return 34'sd65535;
			15: return 34'sd32767;
			16: return 34'sd16383;
			17: return 34'sd8191;
			18: return 34'sd4095;
			19: return 34'sd2047;
			20: return 34'sd1023;
			21: return 34'sd511;
			22: return 34'sd255;
			23: return 34'sd127;
			24: return 34'sd63;
			25: return 34'sd31;
			26: return 34'sd15;
			27: return 34'sd7;
			28: return 34'sd3;
			29: return 34'sd1;
			default: return '0;
		endcase
	endfunction

endpackage

[src/rpt_sincos.sv]
// Pipelined rotation-mode CORDIC giving the Q.16 sine and cosine of a half angle.
module rpt_sincos (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [15:0]                angle,
	output logic signed [rpt_pkg::SCW-1:0]    sin_val,
	output logic signed [rpt_pkg::SCW-1:0]    cos_val
);

	localparam int N = rpt_pkg::NSTG;
	localparam int AW = rpt_pkg::AW;
	localparam int SCW = rpt_pkg::SCW;

	logic signed [AW-1:0] th_full;
	logic signed [AW-1:0] th_red;
	logic                 neg_red;

	logic signed [AW-1:0] th_q [0:N];
	logic signed [AW-1:0] x_q [0:N];
	logic signed [AW-1:0] y_q [0:N];
	logic                 neg_q [0:N];

	logic signed [AW-1:0] xn;
	logic signed [AW-1:0] yn;
	logic signed [AW-1:0] xr;
	logic signed [AW-1:0] yr;

	// The Q3.13 angle times 2^16 is the half angle in Q.30.
	always_comb begin
		th_full = {{(AW-32){angle[15]}}, angle, 16'h0000};
		th_red = th_full;
		neg_red = 1'b0;
		if (th_full > rpt_pkg::PI_HALF_Q30) begin
			th_red = th_full - rpt_pkg::PI_Q30;
			neg_red = 1'b1;
		end else if (th_full < -rpt_pkg::PI_HALF_Q30) begin
			th_red = th_full + rpt_pkg::PI_Q30;
			neg_red = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			th_q[0] <= th_red;
			x_q[0] <= rpt_pkg::CORDIC_K_Q30;
			y_q[0] <= '0;
			neg_q[0] <= neg_red;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				neg_q[i+1] <= neg_q[i];
				if (!th_q[i][AW-1]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					th_q[i+1] <= th_q[i] - rpt_pkg::ang_at(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					th_q[i+1] <= th_q[i] + rpt_pkg::ang_at(i);
				end
			end
		end
	end

	always_comb begin
		xn = neg_q[N] ? -x_q[N] : x_q[N];
		yn = neg_q[N] ? -y_q[N] : y_q[N];
		xr = xn + 34'sd8192;
		yr = yn + 34'sd8192;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= xr[SCW+13:14];
			sin_val <= yr[SCW+13:14];
		end
	end

endmodule

[src/rpt_vec.sv]
// Pipelined vectoring-mode CORDIC giving atan2(y, x) in Q.30 radians.
module rpt_vec (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [rpt_pkg::VW-1:0]    y_in,
	input  logic signed [rpt_pkg::VW-1:0]    x_in,
	output logic signed [rpt_pkg::AW-1:0]    z_out
);

	localparam int N = rpt_pkg::NSTG;
	localparam int AW = rpt_pkg::AW;
	localparam int VW = rpt_pkg::VW;

	logic signed [VW-1:0] x_pre;
	logic signed [VW-1:0] y_pre;
	logic signed [AW-1:0] z_pre;

	logic signed [VW-1:0] x_q [0:N];
	logic signed [VW-1:0] y_q [0:N];
	logic signed [AW-1:0] z_q [0:N];
	logic                 zero_q [0:N];

	// A vector in the left half plane is turned by a quarter turn first.
	always_comb begin
		x_pre = x_in;
		y_pre = y_in;
		z_pre = '0;
		if (x_in[VW-1]) begin
			if (!y_in[VW-1]) begin
				x_pre = y_in;
				y_pre = -x_in;
				z_pre = rpt_pkg::PI_HALF_Q30;
			end else begin
				x_pre = -y_in;
				y_pre = x_in;
				z_pre = -rpt_pkg::PI_HALF_Q30;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= x_pre;
			y_q[0] <= y_pre;
			z_q[0] <= z_pre;
			zero_q[0] <= (x_in == '0) && (y_in == '0);
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				zero_q[i+1] <= zero_q[i];
				if (!y_q[i][VW-1] && (y_q[i] != '0)) begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + rpt_pkg::ang_at(i);
				end else begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - rpt_pkg::ang_at(i);
				end
			end
		end
	end

	// The angle of the zero vector is defined as zero.
	assign z_out = zero_q[N] ? '0 : z_q[N];

endmodule

[src/rigid_pose_transform_top.sv]
// Top level of the rigid pose transform: position rotation, attitude composition, output buffer.
// Throughput: one pose per cycle while the skid register is empty; every stage is a register
// and all stages advance together. The pipeline depth is set by the half-angle CORDIC, the
// 31-step square root and the vectoring CORDIC of the pitch path in series; roll, yaw and
// position are delayed to line up.
// Reset (arst_n low, asynchronous) empties the pipeline and output buffer, and loads the
// identity rotation with zero translation; data registers are not reset.
module rigid_pose_transform_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pose_valid,
	output logic                          pose_ready,
	input  rpt_pkg::pose_t                pose,
	output logic                          result_valid,
	input  logic                          result_ready,
	output rpt_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rpt_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [31:0]                   cfg_data
);

	localparam int N = rpt_pkg::NSTG;
	localparam int AW = rpt_pkg::AW;
	localparam int SCW = rpt_pkg::SCW;
	localparam int VW = rpt_pkg::VW;
	localparam int ISQ = 31;
	localparam int ALN = ISQ + 2;
	// Stage of the Euler terms, and the last pipeline stage.
	localparam int EST = N + 9;
	localparam int LST = EST + ALN + N + 1;
	localparam int FLG = LST - EST;

	logic adv;

	logic signed [15:0] rot_w_q;
	logic signed [15:0] rot_x_q;
	logic signed [15:0] rot_y_q;
	logic signed [15:0] rot_z_q;
	logic signed [31:0] shift_x_q;
	logic signed [31:0] shift_y_q;
	logic signed [31:0] shift_z_q;
	logic signed [15:0] qv [0:3];

	logic vld_s [1:LST];

	// Position path.
	logic signed [47:0] pm_s1 [0:11];
	logic signed [49:0] tsum [0:3];
	logic signed [35:0] t_s2 [0:3];
	logic signed [51:0] tm_s3 [0:11];
	logic signed [53:0] rsum [0:2];
	logic signed [39:0] r_s4 [0:2];
	logic signed [40:0] psum [0:2];
	logic [95:0]        pos_d [5:LST];

	// Attitude path.
	logic signed [SCW-1:0] syaw, cyaw, spit, cpit, srol, crol;
	logic signed [35:0]    pr_s1 [0:3];
	logic signed [SCW-1:0] cy_s1, sy_s1;
	logic signed [53:0]    tp_s2 [0:7];
	logic signed [55:0]    asum [0:3];
	logic signed [33:0]    att_s3 [0:3];
	logic signed [49:0]    qm_s4 [0:3][0:3];
	logic signed [51:0]    qsum [0:3];
	logic signed [26:0]    qp_s5 [0:3];
	logic signed [53:0]    em_s6 [0:8];
	logic signed [55:0]    sr_sum, cr_sum, sp_dif, sy_sum, cy_sum, sp_rnd;
	logic signed [55:0]    esr_s7, ecr_s7, esy_s7, ecy_s7;
	logic signed [31:0]    s30_d [0:ALN];
	logic [1:0]            flg_d [0:FLG];
	logic signed [63:0]    sq_full;
	logic [61:0]           sq_s8;
	logic [61:0]           iv_s [0:ISQ];
	logic [61:0]           ir_s [0:ISQ];
	logic signed [VW-1:0]  pit_y, pit_x;
	logic signed [AW-1:0]  roll_z, yaw_z, pitch_z, pitch30;
	logic signed [AW-1:0]  roll_d [1:ALN];
	logic signed [AW-1:0]  yaw_d [1:ALN];

	// Output buffer.
	rpt_pkg::result_t pipe_res;
	rpt_pkg::result_t out_q;
	rpt_pkg::result_t skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;
	logic             out_take;

	function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
		if (v > 41'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -41'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [15:0] ang_out(input logic signed [AW-1:0] a);
		logic signed [AW:0]  r;
		logic signed [AW-17:0] s;
		r = {a[AW-1], a} + 35'sd65536;
		s = r[AW:17];
		if (s > 18'sd32767) begin
			return 16'sh7fff;
		end else if (s < -18'sd32768) begin
			return 16'sh8000;
		end
		return s[15:0];
	endfunction

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_w_q <= 16'sd16384;
			rot_x_q <= '0;
			rot_y_q <= '0;
			rot_z_q <= '0;
			shift_x_q <= '0;
			shift_y_q <= '0;
			shift_z_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				rpt_pkg::REG_ROT_W: rot_w_q <= cfg_data[15:0];
				rpt_pkg::REG_ROT_X: rot_x_q <= cfg_data[15:0];
				rpt_pkg::REG_ROT_Y: rot_y_q <= cfg_data[15:0];
				rpt_pkg::REG_ROT_Z: rot_z_q <= cfg_data[15:0];
				rpt_pkg::REG_SHIFT_X: shift_x_q <= cfg_data;
				rpt_pkg::REG_SHIFT_Y: shift_y_q <= cfg_data;
				rpt_pkg::REG_SHIFT_Z: shift_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign qv[0] = rot_w_q;
	assign qv[1] = rot_x_q;
	assign qv[2] = rot_y_q;
	assign qv[3] = rot_z_q;

	// The whole pipeline moves as one; it halts only while the skid register is full.
	assign adv = !skid_valid_q;
	assign pose_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= pose_valid;
			for (int k = 2; k <= LST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Position: t = q*(0,v), then r = t*conj(q), then the translation.
	always_ff @(posedge clk) begin
		if (adv) begin
			pm_s1[0] <= rot_x_q * pose.pos_x;
			pm_s1[1] <= rot_y_q * pose.pos_y;
			pm_s1[2] <= rot_z_q * pose.pos_z;
			pm_s1[3] <= rot_w_q * pose.pos_x;
			pm_s1[4] <= rot_y_q * pose.pos_z;
			pm_s1[5] <= rot_z_q * pose.pos_y;
			pm_s1[6] <= rot_w_q * pose.pos_y;
			pm_s1[7] <= rot_x_q * pose.pos_z;
			pm_s1[8] <= rot_z_q * pose.pos_x;
			pm_s1[9] <= rot_w_q * pose.pos_z;
			pm_s1[10] <= rot_x_q * pose.pos_y;
			pm_s1[11] <= rot_y_q * pose.pos_x;
		end
	end

	always_comb begin
		tsum[0] = 50'sd8192 - pm_s1[0] - pm_s1[1] - pm_s1[2];
		tsum[1] = 50'sd8192 + pm_s1[3] + pm_s1[4] - pm_s1[5];
		tsum[2] = 50'sd8192 + pm_s1[6] - pm_s1[7] + pm_s1[8];
		tsum[3] = 50'sd8192 + pm_s1[9] + pm_s1[10] - pm_s1[11];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				t_s2[k] <= tsum[k][49:14];
			end
			tm_s3[0] <= t_s2[0] * rot_x_q;
			tm_s3[1] <= t_s2[1] * rot_w_q;
			tm_s3[2] <= t_s2[2] * rot_z_q;
			tm_s3[3] <= t_s2[3] * rot_y_q;
			tm_s3[4] <= t_s2[0] * rot_y_q;
			tm_s3[5] <= t_s2[1] * rot_z_q;
			tm_s3[6] <= t_s2[2] * rot_w_q;
			tm_s3[7] <= t_s2[3] * rot_x_q;
			tm_s3[8] <= t_s2[0] * rot_z_q;
			tm_s3[9] <= t_s2[1] * rot_y_q;
			tm_s3[10] <= t_s2[2] * rot_x_q;
			tm_s3[11] <= t_s2[3] * rot_w_q;
		end
	end

	always_comb begin
		rsum[0] = 54'sd8192 - tm_s3[0] + tm_s3[1] - tm_s3[2] + tm_s3[3];
		rsum[1] = 54'sd8192 - tm_s3[4] + tm_s3[5] + tm_s3[6] - tm_s3[7];
		rsum[2] = 54'sd8192 - tm_s3[8] - tm_s3[9] + tm_s3[10] + tm_s3[11];
		psum[0] = r_s4[0] + shift_x_q;
		psum[1] = r_s4[1] + shift_y_q;
		psum[2] = r_s4[2] + shift_z_q;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				r_s4[k] <= rsum[k][53:14];
			end
			pos_d[5] <= {sat32(psum[0]), sat32(psum[1]), sat32(psum[2])};
			for (int k = 6; k <= LST; k++) begin
				pos_d[k] <= pos_d[k-1];
			end
		end
	end

	// Attitude: half-angle sines and cosines.
	rpt_sincos u_sc_yaw (
		.clk     (clk),
		.en      (adv),
		.angle   (pose.yaw_in),
		.sin_val (syaw),
		.cos_val (cyaw)
	);

	rpt_sincos u_sc_pitch (
		.clk     (clk),
		.en      (adv),
		.angle   (pose.pitch_in),
		.sin_val (spit),
		.cos_val (cpit)
	);

	rpt_sincos u_sc_roll (
		.clk     (clk),
		.en      (adv),
		.angle   (pose.roll_in),
		.sin_val (srol),
		.cos_val (crol)
	);

	// Attitude quaternion s from triple products, then q*s.
	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s1[0] <= crol * cpit;
			pr_s1[1] <= srol * spit;
			pr_s1[2] <= srol * cpit;
			pr_s1[3] <= crol * spit;
			cy_s1 <= cyaw;
			sy_s1 <= syaw;
			tp_s2[0] <= pr_s1[0] * cy_s1;
			tp_s2[1] <= pr_s1[1] * sy_s1;
			tp_s2[2] <= pr_s1[2] * cy_s1;
			tp_s2[3] <= pr_s1[3] * sy_s1;
			tp_s2[4] <= pr_s1[3] * cy_s1;
			tp_s2[5] <= pr_s1[2] * sy_s1;
			tp_s2[6] <= pr_s1[0] * sy_s1;
			tp_s2[7] <= pr_s1[1] * cy_s1;
		end
	end

	always_comb begin
		asum[0] = 56'sd131072 + tp_s2[0] + tp_s2[1];
		asum[1] = 56'sd131072 + tp_s2[2] - tp_s2[3];
		asum[2] = 56'sd131072 + tp_s2[4] + tp_s2[5];
		asum[3] = 56'sd131072 + tp_s2[6] - tp_s2[7];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				att_s3[k] <= asum[k][51:18];
			end
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					qm_s4[i][j] <= qv[i] * att_s3[j];
				end
			end
		end
	end

	always_comb begin
		qsum[0] = 52'sd8388608 + qm_s4[0][0] - qm_s4[1][1] - qm_s4[2][2] - qm_s4[3][3];
		qsum[1] = 52'sd8388608 + qm_s4[0][1] + qm_s4[1][0] + qm_s4[2][3] - qm_s4[3][2];
		qsum[2] = 52'sd8388608 + qm_s4[0][2] - qm_s4[1][3] + qm_s4[2][0] + qm_s4[3][1];
		qsum[3] = 52'sd8388608 + qm_s4[0][3] + qm_s4[1][2] - qm_s4[2][1] + qm_s4[3][0];
	end

	// Euler terms in Q.40; products indexed w=0, x=1, y=2, z=3.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				qp_s5[k] <= qsum[k][50:24];
			end
			em_s6[0] <= qp_s5[0] * qp_s5[1];
			em_s6[1] <= qp_s5[2] * qp_s5[3];
			em_s6[2] <= qp_s5[1] * qp_s5[1];
			em_s6[3] <= qp_s5[2] * qp_s5[2];
			em_s6[4] <= qp_s5[0] * qp_s5[2];
			em_s6[5] <= qp_s5[3] * qp_s5[1];
			em_s6[6] <= qp_s5[0] * qp_s5[3];
			em_s6[7] <= qp_s5[1] * qp_s5[2];
			em_s6[8] <= qp_s5[3] * qp_s5[3];
		end
	end

	always_comb begin
		sr_sum = em_s6[0] + em_s6[1];
		cr_sum = em_s6[2] + em_s6[3];
		sp_dif = em_s6[4] - em_s6[5];
		sy_sum = em_s6[6] + em_s6[7];
		cy_sum = em_s6[3] + em_s6[8];
		sp_rnd = {sp_dif[54:0], 1'b0} + 56'sd512;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			esr_s7 <= {sr_sum[54:0], 1'b0};
			ecr_s7 <= (56'sd1 <<< 40) - {cr_sum[54:0], 1'b0};
			esy_s7 <= {sy_sum[54:0], 1'b0};
			ecy_s7 <= (56'sd1 <<< 40) - {cy_sum[54:0], 1'b0};
			s30_d[0] <= sp_rnd[41:10];
			// Gimbal lock: bit 1 for sinp at or above one, bit 0 at or below minus one.
			flg_d[0] <= {sp_dif >= (56'sd1 <<< 39), sp_dif <= -(56'sd1 <<< 39)};
			for (int k = 1; k <= ALN; k++) begin
				s30_d[k] <= s30_d[k-1];
			end
			for (int k = 1; k <= FLG; k++) begin
				flg_d[k] <= flg_d[k-1];
			end
		end
	end

	// Pitch cosine: floor square root of 2^60 - s30^2, one result bit per stage.
	assign sq_full = s30_d[0] * s30_d[0];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s8 <= sq_full[61:0];
			iv_s[0] <= (62'd1 << 60) - sq_s8;
			ir_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < ISQ; j++) begin : g_isqrt
		localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
		logic [61:0] trial;
		assign trial = ir_s[j] + BIT;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (iv_s[j] >= trial) begin
					iv_s[j+1] <= iv_s[j] - trial;
					ir_s[j+1] <= (ir_s[j] >> 1) + BIT;
				end else begin
					iv_s[j+1] <= iv_s[j];
					ir_s[j+1] <= ir_s[j] >> 1;
				end
			end
		end
	end

	assign pit_y = {{(VW-32){s30_d[ALN][31]}}, s30_d[ALN]};
	assign pit_x = {{(VW-ISQ){1'b0}}, ir_s[ISQ][ISQ-1:0]};

	rpt_vec u_vec_roll (
		.clk   (clk),
		.en    (adv),
		.y_in  (esr_s7),
		.x_in  (ecr_s7),
		.z_out (roll_z)
	);

	rpt_vec u_vec_yaw (
		.clk   (clk),
		.en    (adv),
		.y_in  (esy_s7),
		.x_in  (ecy_s7),
		.z_out (yaw_z)
	);

	rpt_vec u_vec_pitch (
		.clk   (clk),
		.en    (adv),
		.y_in  (pit_y),
		.x_in  (pit_x),
		.z_out (pitch_z)
	);

	// Roll and yaw wait for the square root of the pitch path.
	always_ff @(posedge clk) begin
		if (adv) begin
			roll_d[1] <= roll_z;
			yaw_d[1] <= yaw_z;
			for (int k = 2; k <= ALN; k++) begin
				roll_d[k] <= roll_d[k-1];
				yaw_d[k] <= yaw_d[k-1];
			end
		end
	end

	always_comb begin
		if (flg_d[FLG][1]) begin
			pitch30 = rpt_pkg::PI_HALF_Q30;
		end else if (flg_d[FLG][0]) begin
			pitch30 = -rpt_pkg::PI_HALF_Q30;
		end else begin
			pitch30 = pitch_z;
		end
		pipe_res.out_x = pos_d[LST][95:64];
		pipe_res.out_y = pos_d[LST][63:32];
		pipe_res.out_z = pos_d[LST][31:0];
		pipe_res.yaw_out = ang_out(yaw_d[ALN]);
		pipe_res.pitch_out = ang_out(pitch30);
		pipe_res.roll_out = ang_out(roll_d[ALN]);
	end

	// Output register with a skid register behind it.
	assign out_take = out_valid_q && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (vld_s[LST]) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (vld_s[LST]) begin
			if (out_valid_q && !out_take) begin
				skid_q <= pipe_res;
			end else begin
				out_q <= pipe_res;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !result_ready && vld_s[LST]))
		else $error("skid register filled without a stalled output");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && result_ready |=> result_valid && !skid_valid_q)
		else $error("skid register did not move to the output after a transfer");
`endif

endmodule

[test/testbench.sv]
// Self-checking testbench for the rigid pose transform: directed and random poses under several transforms.
module testbench;

	localparam longint PI_RAD = 64'sd3373259426;
	localparam longint HALF_PI_RAD = 64'sd1686629713;
	localparam longint GAIN_START = 64'sd652032874;
	localparam longint ONE_Q40 = 64'sd1 <<< 40;
	localparam longint ONE_Q60 = 64'sd1 <<< 60;
	localparam int DRAIN_CYCLES = 2 * rpt_pkg::NSTG + 60;
	localparam int STALL_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pose_valid = 1'b0;
	logic pose_ready;
	rpt_pkg::pose_t pose = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	rpt_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rpt_pkg::CFG_IW-1:0] cfg_index = rpt_pkg::REG_ROT_W;
	logic [31:0] cfg_data = '0;

	rpt_pkg::pose_t pose_q[$];
	rpt_pkg::result_t transformed_q[$];
	longint rot[4];
	longint shift[3];
	longint atan_step[30] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
		65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
		15, 7, 3, 1};
	int send_idle = 0;
	int recv_stall = 0;
	int hold_off = 0;
	int errors = 0;
	int quiet_cycles = 0;

	rigid_pose_transform_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.pose_valid(pose_valid), .pose_ready(pose_ready), .pose(pose),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic longint rnd_shr(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Rotation-mode CORDIC on a Q.30 half angle; sine and cosine come back in Q.16.
	function automatic void half_sin_cos(input longint th, output longint sn,
			output longint cs);
		longint x, y, dx, dy;
		bit flip;
		x = GAIN_START;
		y = 0;
		flip = 1'b0;
		if (th > HALF_PI_RAD) begin
			th -= PI_RAD;
			flip = 1'b1;
		end else if (th < -HALF_PI_RAD) begin
			th += PI_RAD;
			flip = 1'b1;
		end
		for (int i = 0; i < rpt_pkg::NSTG; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (th >= 0) begin
				x -= dx; y += dy; th -= atan_step[i];
			end else begin
				x += dx; y -= dy; th += atan_step[i];
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		sn = rnd_shr(y, 14);
		cs = rnd_shr(x, 14);
	endfunction

	function automatic longint atan2_q30(longint y, longint x);
		longint z, t, dx, dy;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = HALF_PI_RAD;
			end else begin
				x = -y; y = t; z = -HALF_PI_RAD;
			end
		end
		for (int i = 0; i < rpt_pkg::NSTG; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_step[i];
			end else begin
				x -= dx; y += dy; z -= atan_step[i];
			end
		end
		return z;
	endfunction

	function automatic longint floor_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic logic [15:0] to_q13(longint a30);
		return 16'(clip(rnd_shr(a30, 17), -32768, 32767));
	endfunction

	function automatic rpt_pkg::result_t transform_pose(rpt_pkg::pose_t p);
		rpt_pkg::result_t r;
		longint w, a, b, c, vx, vy, vz, tw, tx, ty, tz;
		longint px, py, pz, syw, cyw, spt, cpt, srl, crl;
		longint sw, sx, sy, sz, qw, qx, qy, qz, esr, ecr, esp, esy, ecy;
		longint s30, pitch;
		w = rot[0]; a = rot[1]; b = rot[2]; c = rot[3];
		vx = p.pos_x; vy = p.pos_y; vz = p.pos_z;
		tw = rnd_shr(-a * vx - b * vy - c * vz, 14);
		tx = rnd_shr(w * vx + b * vz - c * vy, 14);
		ty = rnd_shr(w * vy - a * vz + c * vx, 14);
		tz = rnd_shr(w * vz + a * vy - b * vx, 14);
		px = rnd_shr(-tw * a + tx * w - ty * c + tz * b, 14);
		py = rnd_shr(-tw * b + tx * c + ty * w - tz * a, 14);
		pz = rnd_shr(-tw * c - tx * b + ty * a + tz * w, 14);
		r.out_x = 32'(clip(px + shift[0], -64'sd2147483648, 64'sd2147483647));
		r.out_y = 32'(clip(py + shift[1], -64'sd2147483648, 64'sd2147483647));
		r.out_z = 32'(clip(pz + shift[2], -64'sd2147483648, 64'sd2147483647));

		half_sin_cos(longint'(p.yaw_in) * 65536, syw, cyw);
		half_sin_cos(longint'(p.pitch_in) * 65536, spt, cpt);
		half_sin_cos(longint'(p.roll_in) * 65536, srl, crl);
		sw = rnd_shr(crl * cpt * cyw + srl * spt * syw, 18);
		sx = rnd_shr(srl * cpt * cyw - crl * spt * syw, 18);
		sy = rnd_shr(crl * spt * cyw + srl * cpt * syw, 18);
		sz = rnd_shr(crl * cpt * syw - srl * spt * cyw, 18);

		qw = rnd_shr(w * sw - a * sx - b * sy - c * sz, 24);
		qx = rnd_shr(w * sx + a * sw + b * sz - c * sy, 24);
		qy = rnd_shr(w * sy - a * sz + b * sw + c * sx, 24);
		qz = rnd_shr(w * sz + a * sy - b * sx + c * sw, 24);

		esr = 2 * (qw * qx + qy * qz);
		ecr = ONE_Q40 - 2 * (qx * qx + qy * qy);
		esp = 2 * (qw * qy - qz * qx);
		esy = 2 * (qw * qz + qx * qy);
		ecy = ONE_Q40 - 2 * (qy * qy + qz * qz);
		// At gimbal lock the pitch is pinned to a quarter turn.
		if (esp >= ONE_Q40) begin
			pitch = HALF_PI_RAD;
		end else if (esp <= -ONE_Q40) begin
			pitch = -HALF_PI_RAD;
		end else begin
			s30 = rnd_shr(esp, 10);
			pitch = atan2_q30(s30, floor_sqrt(longint'(ONE_Q60 - s30 * s30)));
		end
		r.yaw_out = to_q13(atan2_q30(esy, ecy));
		r.pitch_out = to_q13(pitch);
		r.roll_out = to_q13(atan2_q30(esr, ecr));
		return r;
	endfunction

	always @(posedge clk) begin
		if (pose_valid && pose_ready) transformed_q.push_back(transform_pose(pose));
		if (!pose_valid || pose_ready) begin
			if (arst_n && pose_q.size() > 0 && $urandom_range(99) >= send_idle) begin
				pose_valid <= 1'b1;
				pose <= pose_q.pop_front();
			end else begin
				pose_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		rpt_pkg::result_t want;
		if (result_valid && result_ready) begin
			if (transformed_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transfer, got %p", $time, result);
			end else begin
				want = transformed_q.pop_front();
				check_field("out_x", want.out_x, result.out_x);
				check_field("out_y", want.out_y, result.out_y);
				check_field("out_z", want.out_z, result.out_z);
				check_field("yaw_out", want.yaw_out, result.yaw_out);
				check_field("pitch_out", want.pitch_out, result.pitch_out);
				check_field("roll_out", want.roll_out, result.roll_out);
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= arst_n && ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if ((pose_valid && pose_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[rigid_pose_transform_top] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic wait_drained();
		while (pose_q.size() != 0 || pose_valid || transformed_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [rpt_pkg::CFG_IW-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx <= rpt_pkg::REG_ROT_Z) rot[idx] = longint'(signed'(val[15:0]));
		else if (idx <= rpt_pkg::REG_SHIFT_Z)
			shift[idx - rpt_pkg::REG_SHIFT_X] = longint'(signed'(val));
	endtask

	task automatic load_transform(logic [15:0] w, logic [15:0] x, logic [15:0] y,
			logic [15:0] z, logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		// Upper bits of the quaternion words are don't-care, so randomize them.
		write_reg(rpt_pkg::REG_ROT_W, {16'($urandom), w});
		write_reg(rpt_pkg::REG_ROT_X, {16'($urandom), x});
		write_reg(rpt_pkg::REG_ROT_Y, {16'($urandom), y});
		write_reg(rpt_pkg::REG_ROT_Z, {16'($urandom), z});
		write_reg(rpt_pkg::REG_SHIFT_X, sx);
		write_reg(rpt_pkg::REG_SHIFT_Y, sy);
		write_reg(rpt_pkg::REG_SHIFT_Z, sz);
		write_reg(3'd7, $urandom);
	endtask

	function automatic rpt_pkg::pose_t random_pose();
		rpt_pkg::pose_t p;
		p = {$urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom)};
		// Keep a share of poses small so that saturation does not hide the rotation.
		if ($urandom_range(2) == 0) begin
			p.pos_x = $signed(p.pos_x) >>> 12;
			p.pos_y = $signed(p.pos_y) >>> 12;
			p.pos_z = $signed(p.pos_z) >>> 12;
		end
		return p;
	endfunction

	function automatic rpt_pkg::pose_t make_pose(int x, int y, int z, int yw, int pt, int rl);
		rpt_pkg::pose_t p;
		p.pos_x = x; p.pos_y = y; p.pos_z = z;
		p.yaw_in = 16'(yw); p.pitch_in = 16'(pt); p.roll_in = 16'(rl);
		return p;
	endfunction

	initial begin
		rot = '{16384, 0, 0, 0};
		shift = '{0, 0, 0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		pose_q.push_back(make_pose(0, 0, 0, 0, 0, 0));
		pose_q.push_back(make_pose(32'h7fffffff, 32'h80000000, 1, 32767, 32767, 32767));
		pose_q.push_back(make_pose(32'h80000000, 32'h7fffffff, -1, -32768, -32768, -32768));
		pose_q.push_back(make_pose(65536, -65536, 12345, 12868, 12868, 0));
		pose_q.push_back(make_pose(1, 2, 3, 0, -12868, 25736));
		pose_q.push_back(make_pose(-7, 9, 0, 25736, 0, -25736));
		pose_q.push_back(make_pose(0, 0, 32'h7fffffff, 12867, 12869, -12869));
		load_transform(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		pose_q.push_back(make_pose(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 2, 3));
		pose_q.push_back(make_pose(32'h80000000, 0, 0, 32767, 0, 0));
		pose_q.push_back(make_pose(0, 0, 0, 0, 12868, 0));
		load_transform(16'h8000, 16'h8000, 16'h8000, 16'h8000,
			32'h80000000, 32'h80000000, 32'h80000000);
		pose_q.push_back(make_pose(32'h80000000, 32'h80000000, 32'h80000000, -1, -2, -3));
		pose_q.push_back(make_pose(0, 0, 0, 0, 0, 0));
		// A half turn about z, and a zero quaternion.
		load_transform(16'h0000, 16'h0000, 16'h0000, 16'h4000, 65536, -65536, 0);
		pose_q.push_back(make_pose(65536, 131072, -65536, 6434, -3217, 1000));
		load_transform(0, 0, 0, 0, 0, 0, 0);
		pose_q.push_back(make_pose(65536, 131072, -65536, 6434, -3217, 1000));

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0) load_transform(16'h4000, 0, 0, 0, 0, 0, 0);
			else if (ph == 1) load_transform(16'd11585, 0, 0, 16'd11585, 32'h00010000, 0, 0);
			else load_transform($urandom, $urandom, $urandom, $urandom,
				$signed($urandom) >>> 4, $signed($urandom) >>> 4, $urandom);
			send_idle = (ph % 4 == 1 || ph % 4 == 3) ? 45 : 0;
			recv_stall = (ph % 4 == 2 || ph % 4 == 3) ? 45 : 0;
			if (ph % 4 == 3) begin
				send_idle = 18;
				recv_stall = 18;
			end
			if (ph == 2) hold_off = 400;
			for (int n = 0; n < 300; n++) begin
				if (ph == 4 && n == 150) wait_drained();
				pose_q.push_back(random_pose());
				if (n % 50 == 49) @(posedge clk);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("[rigid_pose_transform_top] OK");
		end else begin
			$display("[rigid_pose_transform_top] ERROR");
		end
		$finish;
	end
endmodule

[rigid_pose_transform_top.f]
src/rpt_pkg.sv
src/rpt_sincos.sv
src/rpt_vec.sv
src/rigid_pose_transform_top.sv
test/testbench.sv
